### sv/rlh_pkg.sv
// ----------------------------------------------------------------------------
// rlh_pkg
// Shared types and constants for the request latency histogram core.
// ----------------------------------------------------------------------------
package rlh_pkg;

  localparam int PENDING_TAGS_DEF = 64;
  localparam int HIST_ENTRIES_DEF = 256;
  localparam int BUCKETS_DEF      = 27;
  localparam int COMMANDS_DEF     = 64;

  localparam logic [2:0] OP_START     = 3'd0;
  localparam logic [2:0] OP_DONE      = 3'd1;
  localparam logic [2:0] OP_READ_HIST = 3'd2;
  localparam logic [2:0] OP_READ_CMD  = 3'd3;
  localparam logic [2:0] OP_READ_TOT  = 3'd4;

  localparam logic [2:0] ST_STARTED   = 3'd0;
  localparam logic [2:0] ST_START_FLT = 3'd1;
  localparam logic [2:0] ST_COUNTED   = 3'd2;
  localparam logic [2:0] ST_NO_START  = 3'd3;
  localparam logic [2:0] ST_DONE_FLT  = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_READ      = 3'd6;

  localparam logic [2:0] REG_TIME_UNIT   = 3'd0;
  localparam logic [2:0] REG_ONLY_CMD    = 3'd1;
  localparam logic [2:0] REG_LEAST_BLK   = 3'd2;
  localparam logic [2:0] REG_MOST_BLK    = 3'd3;
  localparam logic [2:0] REG_AVG_MODE    = 3'd4;
  localparam logic [2:0] REG_SPLIT_CMD   = 3'd5;
  localparam logic [2:0] REG_SPLIT_BLK   = 3'd6;

  localparam logic [1:0] UNIT_US = 2'd1;
  localparam logic [1:0] UNIT_MS = 2'd2;

  localparam logic [19:0] DIV_NS = 20'd1;
  localparam logic [19:0] DIV_US = 20'd1000;
  localparam logic [19:0] DIV_MS = 20'd1000000;

  // Reciprocals ceil(2^38 / 1000) and ceil(2^48 / 1000000) for 28-bit digit steps
  localparam logic [28:0] MUL_US = 29'd274877907;
  localparam logic [28:0] MUL_MS = 29'd281474977;

  localparam logic [5:0] CMD_WRITE_TASK = 6'd47;
  localparam logic [5:0] CMD_READ_TASK  = 6'd46;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] latency;
    logic [4:0]  bucket;
    logic [63:0] bucket_total;
    logic        entry_valid;
    logic [5:0]  entry_command;
    logic [15:0] entry_blocks;
    logic [4:0]  entry_bucket;
    logic [63:0] latency_sum;
    logic [63:0] done_count;
  } res_t;

endpackage

### sv/request_latency_histogram_core.sv
// ----------------------------------------------------------------------------
// request_latency_histogram_core
// Card request latency monitor with log2 histogram and per-command stats.
// ----------------------------------------------------------------------------
// Start items pass through DISP and OUT; read items through DISP, RDRES if needed, and OUT.
// A done item passes through FETCH, the eight-digit reciprocal scaling divider
// in DIV, SUM and a SCAN of the used histogram entries before OUT; a filtered
// done goes from FETCH straight to OUT. One item at a time.
// Synchronous reset clears configuration, tag valid bits, command stat valid
// bits, the global sum and the histogram fill count; no clearing pass.
module request_latency_histogram_core
  import rlh_pkg::*;
#(
  parameter int PENDING_TAGS = PENDING_TAGS_DEF,
  parameter int HIST_ENTRIES = HIST_ENTRIES_DEF,
  parameter int BUCKETS      = BUCKETS_DEF,
  parameter int COMMANDS     = COMMANDS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // request_tag, opcode, write_flag, read_flag, block_count, timestamp, entry_index
  input  logic [103:0] s_tdata,
  // command
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // latency, bucket, bucket_total, entry_valid, entry_command, entry_blocks,
  // entry_bucket, latency_sum, done_count
  output logic [295:0] m_tdata,
  // status
  output logic [2:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int TAG_W = (PENDING_TAGS > 1) ? $clog2(PENDING_TAGS) : 1;
  localparam int ENT_W = $clog2(HIST_ENTRIES);
  localparam int CMD_W = $clog2(COMMANDS);
  localparam int KEY_W = 28;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_RDRES = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state;

  logic [1:0]  cfg_unit;
  logic [5:0]  cfg_only;
  logic [15:0] cfg_least, cfg_most;
  logic        cfg_avg, cfg_bycmd, cfg_byblk;

  logic [2:0]  op;
  logic [5:0]  tag, opcode;
  logic        wr, rd;
  logic [15:0] blocks;
  logic [63:0] now;
  logic [7:0]  idx;

  logic [PENDING_TAGS-1:0] pvalid;
  logic [63:0] pend_time_mem [PENDING_TAGS];
  logic [21:0] pend_info_mem [PENDING_TAGS];
  logic [63:0] pend_time_q;
  logic [21:0] pend_info_q;

  logic [COMMANDS-1:0] cvalid;
  logic [127:0] cmd_mem [COMMANDS];
  logic [127:0] cmd_q;

  logic [KEY_W+63:0] hist_mem [HIST_ENTRIES];
  logic [KEY_W+63:0] hist_q;
  logic [ENT_W:0]    fill, scan_idx;
  logic              chk;

  logic [63:0] total_sum;

  logic [5:0]  d_cmd;
  logic [15:0] d_blk;
  logic [63:0] dvd;
  logic [19:0] dvs, rem;
  logic [2:0]  cnt;
  logic [5:0]  lg;
  logic        seen;
  logic        dph;
  logic [7:0]  qd;
  logic [KEY_W-1:0] key;

  res_t res, out_q, disp_res;

  logic [TAG_W-1:0] tag_a;
  logic [CMD_W-1:0] cmd_a;
  logic [ENT_W-1:0] hist_a;
  logic             tag_ok;
  logic             start_flt;
  logic             done_ok;
  logic             out_fire;
  logic [5:0]       map_cmd;
  logic [27:0]      dv;
  logic [28:0]      mul_k;
  logic [56:0]      prod;
  logic [7:0]       q_dig;
  logic [5:0]       bkt;
  logic [63:0]      lat_sum_new, cmd_sum_old, cmd_done_old;
  logic [ENT_W:0]   chk_idx;

  function automatic logic [2:0] msb8(input logic [7:0] v);
    logic [2:0] r;
    r = '0;
    for (int i = 1; i < 8; i++) if (v[i]) r = 3'(i);
    return r;
  endfunction

  assign tag_a   = TAG_W'(32'(tag));
  assign tag_ok  = 32'(tag) < PENDING_TAGS;
  assign cmd_a   = (op == OP_READ_CMD) ? CMD_W'(32'(idx)) : CMD_W'(32'(d_cmd));
  assign chk_idx = scan_idx - 1'b1;
  assign hist_a  = (state == S_SCAN) ? scan_idx[ENT_W-1:0] : ENT_W'(32'(idx));
  assign map_cmd = (opcode == 6'd0 && (wr || rd)) ?
                   (wr ? CMD_WRITE_TASK : CMD_READ_TASK) : opcode;
  assign start_flt = (cfg_only != 6'd0 && cfg_only != map_cmd) ||
                     (cfg_least != 16'd0 && blocks < cfg_least) ||
                     (cfg_most != 16'd0 && blocks > cfg_most);
  assign done_ok = tag_ok && pvalid[tag_a];
  assign dv      = {rem, dvd[63:56]};
  assign mul_k   = (cfg_unit == UNIT_MS) ? MUL_MS : MUL_US;
  assign prod    = 57'(dv) * 57'(mul_k);
  assign q_dig   = (cfg_unit == UNIT_MS) ? prod[55:48] :
                   (cfg_unit == UNIT_US) ? prod[45:38] : dvd[63:56];
  assign bkt     = (32'(lg) >= BUCKETS) ? 6'(BUCKETS - 1) : lg;
  assign cmd_sum_old  = cvalid[cmd_a] ? cmd_q[63:0]   : 64'd0;
  assign cmd_done_old = cvalid[cmd_a] ? cmd_q[127:64] : 64'd0;
  assign lat_sum_new  = cfg_avg ? cmd_sum_old + dvd : total_sum + dvd;
  assign out_fire     = (state == S_OUT) && (!m_tvalid || m_tready);

  assign s_tready = (state == S_IDLE);
  assign m_tuser  = out_q.status;
  assign m_tdata  = {7'd0, out_q.done_count, out_q.latency_sum, out_q.entry_bucket,
                     out_q.entry_blocks, out_q.entry_command, out_q.entry_valid,
                     out_q.bucket_total, out_q.bucket, out_q.latency};

  always_comb begin
    disp_res = '0;
    disp_res.status = ST_READ;
    case (op)
      OP_START: disp_res.status = start_flt ? ST_START_FLT :
                                  (!tag_ok ? ST_FULL : ST_STARTED);
      OP_DONE: if (!done_ok) disp_res.status = ST_NO_START;
      OP_READ_TOT: disp_res.latency_sum = total_sum;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    pend_time_q <= pend_time_mem[tag_a];
    pend_info_q <= pend_info_mem[tag_a];
    cmd_q       <= cmd_mem[cmd_a];
    hist_q      <= hist_mem[hist_a];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_unit  <= '0;
      cfg_only  <= '0;
      cfg_least <= '0;
      cfg_most  <= '0;
      cfg_avg   <= 1'b0;
      cfg_bycmd <= 1'b0;
      cfg_byblk <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_UNIT: cfg_unit  <= cfg_data[1:0];
        REG_ONLY_CMD:  cfg_only  <= cfg_data[5:0];
        REG_LEAST_BLK: cfg_least <= cfg_data;
        REG_MOST_BLK:  cfg_most  <= cfg_data;
        REG_AVG_MODE:  cfg_avg   <= cfg_data[0];
        REG_SPLIT_CMD: cfg_bycmd <= cfg_data[0];
        REG_SPLIT_BLK: cfg_byblk <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pvalid    <= '0;
      cvalid    <= '0;
      total_sum <= '0;
      fill      <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (out_fire) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op     <= s_tuser;
            tag    <= s_tdata[5:0];
            opcode <= s_tdata[11:6];
            wr     <= s_tdata[12];
            rd     <= s_tdata[13];
            blocks <= s_tdata[29:14];
            now    <= s_tdata[93:30];
            idx    <= s_tdata[101:94];
            if (s_tuser <= OP_READ_TOT) state <= S_DISP;
          end
        end
        S_DISP: begin
          res <= disp_res;
          case (op)
            OP_START: begin
              if (!start_flt && tag_ok) begin
                pvalid[tag_a]        <= 1'b1;
                pend_time_mem[tag_a] <= now;
                pend_info_mem[tag_a] <= {map_cmd, blocks};
              end
              state <= S_OUT;
            end
            OP_DONE: begin
              if (done_ok) begin
                pvalid[tag_a] <= 1'b0;
                state <= S_FETCH;
              end else begin
                state <= S_OUT;
              end
            end
            OP_READ_HIST: state <= (32'(idx) < 32'(fill)) ? S_RDRES : S_OUT;
            OP_READ_CMD:  state <= (32'(idx) < COMMANDS) ? S_RDRES : S_OUT;
            default:      state <= S_OUT;
          endcase
        end
        S_FETCH: begin
          d_cmd <= pend_info_q[21:16];
          d_blk <= pend_info_q[15:0];
          if (cfg_only != 6'd0 && cfg_only != pend_info_q[21:16]) begin
            res.status <= ST_DONE_FLT;
            state <= S_OUT;
          end else begin
            dvd  <= now - pend_time_q;
            dvs  <= (cfg_unit == UNIT_US) ? DIV_US : (cfg_unit == UNIT_MS) ? DIV_MS : DIV_NS;
            rem  <= '0;
            cnt  <= 3'd7;
            dph  <= 1'b0;
            lg   <= '0;
            seen <= 1'b0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!dph) begin
            qd  <= q_dig;
            dph <= 1'b1;
          end else begin
            rem <= 20'(dv - 28'(qd) * 28'(dvs));
            dvd <= {dvd[55:0], qd};
            if (qd != 8'd0 && !seen) begin
              lg   <= {cnt, msb8(qd)};
              seen <= 1'b1;
            end
            cnt <= cnt - 1'b1;
            dph <= 1'b0;
            if (cnt == 3'd0) state <= S_SUM;
          end
        end
        S_SUM: begin
          res.latency     <= dvd;
          res.bucket      <= bkt[4:0];
          res.latency_sum <= lat_sum_new;
          if (cfg_avg) begin
            cmd_mem[cmd_a] <= {cmd_done_old + 64'd1, lat_sum_new};
            cvalid[cmd_a]  <= 1'b1;
            res.done_count <= cmd_done_old + 64'd1;
          end else begin
            total_sum      <= lat_sum_new;
            res.done_count <= cmd_done_old;
          end
          key      <= {bkt, cfg_bycmd ? d_cmd : 6'd0, cfg_byblk ? d_blk : 16'd0};
          scan_idx <= '0;
          chk      <= 1'b0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          if (chk && hist_q[KEY_W-1:0] == key) begin
            hist_mem[chk_idx[ENT_W-1:0]] <= {hist_q[KEY_W+63:KEY_W] + 64'd1, key};
            res.status       <= ST_COUNTED;
            res.bucket_total <= hist_q[KEY_W+63:KEY_W] + 64'd1;
            state <= S_OUT;
          end else if (scan_idx < fill) begin
            scan_idx <= scan_idx + 1'b1;
            chk      <= 1'b1;
          end else if (32'(fill) < HIST_ENTRIES) begin
            hist_mem[fill[ENT_W-1:0]] <= {64'd1, key};
            fill             <= fill + 1'b1;
            res.status       <= ST_COUNTED;
            res.bucket_total <= 64'd1;
            state <= S_OUT;
          end else begin
            res.status <= ST_FULL;
            state <= S_OUT;
          end
        end
        S_RDRES: begin
          if (op == OP_READ_HIST) begin
            res.bucket_total  <= hist_q[KEY_W+63:KEY_W];
            res.entry_valid   <= 1'b1;
            res.entry_command <= hist_q[21:16];
            res.entry_blocks  <= hist_q[15:0];
            res.entry_bucket  <= hist_q[26:22];
          end else begin
            res.latency_sum <= cmd_sum_old;
            res.done_count  <= cmd_done_old;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_fire) begin
            out_q <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= HIST_ENTRIES) else $error("histogram fill count overflow");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> scan_idx <= fill) else $error("scan ran past fill");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_OUT) else $error("result outside output step");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    state == S_SUM |-> $past(state) == S_DIV && $past(cnt) == 3'd0)
    else $error("divider finished early");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives start, done, read and unknown items into the request latency
// histogram core over the stream ports and rewrites the configuration
// between phases. A scoreboard keeps its own copy of the tag table, the
// per-command stats and the histogram. It predicts every result and checks
// each field of the results in order.
// ----------------------------------------------------------------------------
module tb_top;
  import rlh_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int SETTLE_CYCLES = 400;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 175;

  class latency_scoreboard;
    logic [1:0]  unit_sel;
    logic [5:0]  only_cmd;
    logic [15:0] least_blk, most_blk;
    logic        avg_mode, split_cmd, split_blk;
    logic        tag_busy [PENDING_TAGS_DEF];
    logic [63:0] tag_time [PENDING_TAGS_DEF];
    logic [5:0]  tag_cmd [PENDING_TAGS_DEF];
    logic [15:0] tag_blk [PENDING_TAGS_DEF];
    logic [63:0] cmd_sum [COMMANDS_DEF];
    logic [63:0] cmd_done [COMMANDS_DEF];
    logic [63:0] global_sum;
    logic        slot_used [HIST_ENTRIES_DEF];
    logic [26:0] slot_key [HIST_ENTRIES_DEF];
    logic [63:0] slot_count [HIST_ENTRIES_DEF];
    res_t        pending_results [$];
    int          errors;

    function new();
      unit_sel = 0; only_cmd = 0; least_blk = 0; most_blk = 0;
      avg_mode = 0; split_cmd = 0; split_blk = 0; global_sum = 0; errors = 0;
      foreach (tag_busy[i]) tag_busy[i] = 0;
      foreach (cmd_sum[i]) begin
        cmd_sum[i] = 0;
        cmd_done[i] = 0;
      end
      foreach (slot_used[i]) slot_used[i] = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_TIME_UNIT: unit_sel = val[1:0];
        REG_ONLY_CMD:  only_cmd = val[5:0];
        REG_LEAST_BLK: least_blk = val;
        REG_MOST_BLK:  most_blk = val;
        REG_AVG_MODE:  avg_mode = val[0];
        REG_SPLIT_CMD: split_cmd = val[0];
        REG_SPLIT_BLK: split_blk = val[0];
        default: ;
      endcase
    endfunction

    function void note_item(logic [2:0] op, logic [5:0] tag, logic [5:0] opcode,
                            logic wr, logic rd, logic [15:0] blocks,
                            logic [63:0] ts, logic [7:0] idx);
      res_t r;
      logic [5:0] cmd;
      logic [15:0] blk;
      logic [63:0] delta, sum, v;
      logic [5:0] bkt;
      logic [26:0] key;
      int found, free_slot;
      r = '0;
      found = -1;
      free_slot = -1;
      if (op > OP_READ_TOT) return;
      case (op)
        OP_START: begin
          cmd = opcode;
          if (cmd == 0 && (wr || rd)) cmd = wr ? CMD_WRITE_TASK : CMD_READ_TASK;
          if ((only_cmd != 0 && only_cmd != cmd) ||
              (least_blk != 0 && blocks < least_blk) ||
              (most_blk != 0 && blocks > most_blk)) begin
            r.status = ST_START_FLT;
          end else begin
            tag_busy[tag] = 1;
            tag_time[tag] = ts;
            tag_cmd[tag] = cmd;
            tag_blk[tag] = blocks;
            r.status = ST_STARTED;
          end
        end
        OP_DONE: begin
          if (!tag_busy[tag]) begin
            r.status = ST_NO_START;
          end else begin
            cmd = tag_cmd[tag];
            blk = tag_blk[tag];
            tag_busy[tag] = 0;
            if (only_cmd != 0 && only_cmd != cmd) begin
              r.status = ST_DONE_FLT;
            end else begin
              delta = ts - tag_time[tag];
              if (unit_sel == UNIT_US) delta = delta / 64'd1000;
              else if (unit_sel == UNIT_MS) delta = delta / 64'd1000000;
              if (avg_mode) begin
                cmd_sum[cmd] += delta;
                cmd_done[cmd] += 1;
                sum = cmd_sum[cmd];
              end else begin
                global_sum += delta;
                sum = global_sum;
              end
              bkt = 0;
              v = delta;
              while (v > 1) begin
                v = v >> 1;
                bkt++;
              end
              if (bkt >= BUCKETS_DEF) bkt = 6'(BUCKETS_DEF - 1);
              key = {bkt[4:0], split_cmd ? cmd : 6'd0, split_blk ? blk : 16'd0};
              for (int i = 0; i < HIST_ENTRIES_DEF; i++) begin
                if (slot_used[i]) begin
                  if (found < 0 && slot_key[i] == key) found = i;
                end else if (free_slot < 0) begin
                  free_slot = i;
                end
              end
              if (found < 0 && free_slot >= 0) begin
                found = free_slot;
                slot_used[found] = 1;
                slot_key[found] = key;
                slot_count[found] = 0;
              end
              r.latency = delta;
              r.bucket = bkt[4:0];
              r.latency_sum = sum;
              r.done_count = cmd_done[cmd];
              if (found < 0) begin
                r.status = ST_FULL;
              end else begin
                slot_count[found] += 1;
                r.status = ST_COUNTED;
                r.bucket_total = slot_count[found];
              end
            end
          end
        end
        OP_READ_HIST: begin
          r.status = ST_READ;
          if (slot_used[idx]) begin
            r.bucket_total = slot_count[idx];
            r.entry_valid = 1;
            r.entry_command = slot_key[idx][21:16];
            r.entry_blocks = slot_key[idx][15:0];
            r.entry_bucket = slot_key[idx][26:22];
          end
        end
        OP_READ_CMD: begin
          r.status = ST_READ;
          if (idx < COMMANDS_DEF) begin
            r.latency_sum = cmd_sum[idx];
            r.done_count = cmd_done[idx];
          end
        end
        default: begin
          r.status = ST_READ;
          r.latency_sum = global_sum;
        end
      endcase
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      errors++;
    endtask

    task compare(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      want = pending_results.pop_front();
      compare("status", got.status, want.status);
      compare("latency", got.latency, want.latency);
      compare("bucket", got.bucket, want.bucket);
      compare("bucket_total", got.bucket_total, want.bucket_total);
      compare("entry_valid", got.entry_valid, want.entry_valid);
      compare("entry_command", got.entry_command, want.entry_command);
      compare("entry_blocks", got.entry_blocks, want.entry_blocks);
      compare("entry_bucket", got.entry_bucket, want.entry_bucket);
      compare("latency_sum", got.latency_sum, want.latency_sum);
      compare("done_count", got.done_count, want.done_count);
    endtask
  endclass

  logic         clk, rst;
  logic         s_tvalid, s_tready;
  logic [103:0] s_tdata;
  logic [2:0]   s_tuser;
  logic         m_tvalid, m_tready;
  logic [295:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [15:0]  cfg_data;

  latency_scoreboard sb;
  int send_idle, recv_idle;
  int cycles;
  logic [63:0] start_stamp [PENDING_TAGS_DEF];

  request_latency_histogram_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("request_latency_histogram_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tuser;
      got.latency = m_tdata[63:0];
      got.bucket = m_tdata[68:64];
      got.bucket_total = m_tdata[132:69];
      got.entry_valid = m_tdata[133];
      got.entry_command = m_tdata[139:134];
      got.entry_blocks = m_tdata[155:140];
      got.entry_bucket = m_tdata[160:156];
      got.latency_sum = m_tdata[224:161];
      got.done_count = m_tdata[288:225];
      sb.check_result(got);
    end
  end

  initial begin
    m_tready = 0;
    forever begin
      @(negedge clk);
      m_tready = ($urandom_range(0, 99) >= recv_idle);
    end
  end

  task send_item(logic [2:0] op, logic [5:0] tag, logic [5:0] opcode, logic wr,
                 logic rd, logic [15:0] blocks, logic [63:0] ts, logic [7:0] idx);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid = 0;
      @(negedge clk);
    end
    s_tvalid = 1;
    s_tuser = op;
    s_tdata = {2'b0, idx, ts, blocks, rd, wr, opcode, tag};
    do @(posedge clk); while (!s_tready);
    sb.note_item(op, tag, opcode, wr, rd, blocks, ts, idx);
    if (op == OP_START) start_stamp[tag] = ts;
    @(negedge clk);
  endtask

  task drain();
    s_tvalid = 0;
    while (sb.pending_results.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task random_item(output bit counted);
    logic [2:0] op;
    logic [5:0] tag, opcode;
    logic wr, rd;
    logic [15:0] blocks;
    logic [63:0] ts, delta;
    int pick;
    pick = $urandom_range(0, 99);
    tag = $urandom_range(0, 63);
    opcode = $urandom_range(0, 63);
    wr = $urandom_range(0, 1);
    rd = $urandom_range(0, 1);
    counted = 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: blocks = $urandom_range(0, 8);
      5, 6, 7: blocks = $urandom_range(0, 4096);
      default: blocks = $urandom_range(0, 65535);
    endcase
    if ($urandom_range(0, 3) == 0) opcode = 0;
    if (sb.only_cmd != 0 && $urandom_range(0, 1)) begin
      opcode = sb.only_cmd;
      if (sb.only_cmd == CMD_WRITE_TASK && $urandom_range(0, 1)) begin
        opcode = 0; wr = 1;
      end else if (sb.only_cmd == CMD_READ_TASK && $urandom_range(0, 1)) begin
        opcode = 0; wr = 0; rd = 1;
      end
    end
    case ($urandom_range(0, 5))
      0: delta = $urandom_range(0, 3);
      1: delta = (64'd1 << $urandom_range(0, 40)) + $urandom_range(0, 7);
      2: delta = $urandom;
      3: delta = {$urandom, $urandom};
      4: delta = 64'd1000 * $urandom_range(0, 100000);
      default: delta = 64'd1000000 * $urandom_range(0, 100000);
    endcase
    if (pick < 40) begin
      op = OP_START;
      ts = {$urandom, $urandom};
    end else if (pick < 75) begin
      op = OP_DONE;
      ts = start_stamp[tag] + delta;
    end else begin
      op = (pick < 85) ? OP_READ_HIST : (pick < 93) ? OP_READ_CMD :
           (pick < 97) ? OP_READ_TOT : 3'($urandom_range(5, 7));
      ts = {$urandom, $urandom};
      if (op > OP_READ_TOT) counted = 0;
    end
    send_item(op, tag, opcode, wr, rd, blocks, ts, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int unit_t [PHASES] = '{0, 1, 2, 3, 0, 1, 2, 0, 1, 0};
    int only_t [PHASES] = '{0, 0, 47, 0, 63, 0, 0, 46, 0, 0};
    int least_t [PHASES] = '{0, 0, 0, 100, 0, 1, 0, 0, 65535, 0};
    int most_t [PHASES] = '{0, 0, 0, 2000, 0, 65535, 0, 0, 0, 3};
    int avg_t [PHASES] = '{0, 1, 1, 0, 1, 0, 1, 1, 0, 1};
    int bycmd_t [PHASES] = '{0, 1, 0, 1, 1, 0, 1, 0, 1, 1};
    int byblk_t [PHASES] = '{0, 0, 1, 0, 1, 1, 0, 1, 0, 1};
    int done_items;
    bit counted;
    sb = new();
    cycles = 0;
    send_idle = 0;
    recv_idle = 0;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = OP_START;
    cfg_we = 0;
    cfg_index = REG_TIME_UNIT;
    cfg_data = '0;
    foreach (start_stamp[i]) start_stamp[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_item(OP_READ_TOT, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_READ_CMD, 0, 0, 0, 0, 0, 0, 8'd255);
    send_item(OP_READ_HIST, 0, 0, 0, 0, 0, 0, 8'd255);
    send_item(3'd5, 0, 0, 0, 0, 0, 0, 0);
    send_item(3'd7, 6'd63, 6'd63, 1, 1, 16'hFFFF, '1, 8'hFF);
    send_item(OP_DONE, 6'd9, 0, 0, 0, 0, 0, 0);
    send_item(OP_START, 0, 0, 1, 1, 16'hFFFF, '1, 0);
    send_item(OP_DONE, 0, 0, 0, 0, 0, 64'd5, 0);
    send_item(OP_DONE, 0, 0, 0, 0, 0, 64'd9, 0);
    send_item(OP_START, 6'd63, 0, 0, 1, 0, 0, 0);
    send_item(OP_DONE, 6'd63, 0, 0, 0, 0, 0, 0);
    send_item(OP_START, 6'd1, 6'd63, 0, 0, 16'd1, 0, 0);
    send_item(OP_DONE, 6'd1, 0, 0, 0, 0, '1, 0);
    send_item(OP_START, 6'd2, 0, 0, 0, 16'd2, 64'd7, 0);
    send_item(OP_DONE, 6'd2, 0, 0, 0, 0, 64'd1007, 0);
    send_item(OP_READ_HIST, 0, 0, 0, 0, 0, 0, 8'd0);
    send_item(OP_READ_HIST, 0, 0, 0, 0, 0, 0, 8'd1);
    send_item(OP_READ_HIST, 0, 0, 0, 0, 0, 0, 8'd3);
    send_item(OP_READ_CMD, 0, 0, 0, 0, 0, 0, 8'd47);
    send_item(OP_READ_CMD, 0, 0, 0, 0, 0, 0, 8'd63);
    send_item(OP_READ_TOT, 0, 0, 0, 0, 0, 0, 0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_TIME_UNIT, 16'(unit_t[p]));
      write_reg(REG_ONLY_CMD, 16'(only_t[p]));
      write_reg(REG_LEAST_BLK, 16'(least_t[p]));
      write_reg(REG_MOST_BLK, 16'(most_t[p]));
      write_reg(REG_AVG_MODE, 16'(avg_t[p]));
      write_reg(REG_SPLIT_CMD, 16'(bycmd_t[p]));
      write_reg(REG_SPLIT_BLK, 16'(byblk_t[p]));
      if (p < 4) begin
        send_idle = 28; recv_idle = 83;
      end else if (p < 7) begin
        send_idle = 83; recv_idle = 28;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        random_item(counted);
        if (counted) done_items++;
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("request_latency_histogram_core: match");
    end else begin
      $display("request_latency_histogram_core: mismatch");
    end
    $finish;
  end

endmodule
